### design/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg - wildcard pattern matcher package
// Shared constants, register indexes and the cell-to-cell link type.
// ----------------------------------------------------------------------------
package wpm_pkg;

	localparam int PATTERN_MAX = 16;
	localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
	localparam int CFG_W       = 64;
	localparam int LEN_FIELD_W = 5;
	localparam int CFG_IDX_W   = 2;

	localparam logic [7:0] STAR_CHAR = 8'h2A;
	localparam logic [7:0] ANY_CHAR  = 8'h3F;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW  = 2'd0,
		REG_PATTERN_HIGH = 2'd1,
		REG_PATTERN_LEN  = 2'd2,
		REG_UNUSED       = 2'd3
	} cfg_reg_t;

	// per-beat control broadcast to every cell
	typedef struct packed {
		logic step;
		logic start;
	} cell_ctrl_t;

	// what one cell hands to the next one up
	typedef struct packed {
		logic base_bit;  // base column bit
		logic old_bit;   // column bit before this beat
		logic new_bit;   // column bit after this beat
	} link_t;

endpackage

### design/wpm_if.sv
// ----------------------------------------------------------------------------
// wpm_if - stream channels of the wildcard pattern matcher
// Valid/ready channels for text bytes in and match results out.
// ----------------------------------------------------------------------------
interface wpm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       start_of_text;

	modport source (output valid, output text_char, output start_of_text, input ready);
	modport sink   (input valid, input text_char, input start_of_text, output ready);
endinterface

interface wpm_out_if;
	logic valid;
	logic ready;
	logic prefix_match;

	modport source (output valid, output prefix_match, input ready);
	modport sink   (input valid, input prefix_match, output ready);
endinterface

### design/wpm_cell.sv
// ----------------------------------------------------------------------------
// wpm_cell - one pattern position
// Holds one column bit and computes its next value from the neighbor below.
// ----------------------------------------------------------------------------
module wpm_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          pattern_char,
	input  logic [7:0]          text_char,
	input  logic                enable,
	input  wpm_pkg::cell_ctrl_t ctrl,
	input  wpm_pkg::link_t      link_in,
	output wpm_pkg::link_t      link_out,
	output logic                col_bit
);
	import wpm_pkg::*;

	logic col_q;
	logic is_star;
	logic hit;
	logic old_bit;
	logic new_bit;
	logic base_bit;

	always_comb begin
		is_star  = (pattern_char == STAR_CHAR);
		hit      = (pattern_char == ANY_CHAR) || (pattern_char == text_char);
		base_bit = enable & is_star & link_in.base_bit;
		old_bit  = ctrl.start ? base_bit : col_q;
		if (!enable) begin
			new_bit = 1'b0;
		end else if (is_star) begin
			// star: empty run (ripple from below) or one more byte
			new_bit = link_in.new_bit | old_bit;
		end else begin
			new_bit = hit & link_in.old_bit;
		end
	end

	assign link_out = '{base_bit: base_bit, old_bit: old_bit, new_bit: new_bit};
	assign col_bit  = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 1'b0;
		end else if (ctrl.step) begin
			col_q <= new_bit;
		end
	end

endmodule

### design/wpm_out_buf.sv
// ----------------------------------------------------------------------------
// wpm_out_buf - result buffer
// Two-entry buffer so a new beat is taken while a result waits downstream.
// ----------------------------------------------------------------------------
module wpm_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             din,
	output logic             full,
	wpm_out_if.source        out_ch
);
	logic [1:0] count_q;
	logic       head_q;
	logic       tail_q;
	logic       pop;
	logic [1:0] after_pop;

	assign pop       = out_ch.valid & out_ch.ready;
	assign after_pop = count_q - {1'b0, pop};
	assign full      = (count_q == 2'd2);

	assign out_ch.valid        = (count_q != 2'd0);
	assign out_ch.prefix_match = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= after_pop + {1'b0, push};
		end
	end

	always_ff @(posedge clk) begin
		if (pop && count_q == 2'd2) begin
			head_q <= tail_q;
		end
		if (push) begin
			if (after_pop == 2'd0) begin
				head_q <= din;
			end else begin
				tail_q <= din;
			end
		end
	end

endmodule

### design/wildcard_pattern_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher - streamed wildcard match ('?' and '*')
// A row of cells keeps one DP column; every text byte gives a match bit.
// ----------------------------------------------------------------------------
//  channel   dir  payload                      beat
//  text_in   in   text_char, start_of_text     one text byte
//  result    out  prefix_match                 one result per text byte
//  cfg       in   cfg_wr_en/cfg_index/cfg_wdata register write, no read-back
//
// One byte per cycle while text_in.ready is high; each result is registered
// in the result buffer. The star ripple through the cell row is the longest path.
// Reset clears the column, the registers and the result buffer.
// Two results can wait; text_in.ready drops only when both slots are full.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [wpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wpm_pkg::CFG_W-1:0]      cfg_wdata,
	wpm_in_if.sink                         text_in,
	wpm_out_if.source                      result
);
	import wpm_pkg::*;

	logic [CFG_W-1:0]       pat_low_q;
	logic [CFG_W-1:0]       pat_high_q;
	logic [LEN_FIELD_W-1:0] len_q;
	logic [LEN_W-1:0]       len_eff;
	logic [2*CFG_W-1:0]     pat_word;
	cell_ctrl_t             ctrl;
	link_t                  link [PATTERN_MAX+1];
	logic [PATTERN_MAX:0]   new_vec;
	logic [PATTERN_MAX:0]   col_vec;
	logic                   buf_full;
	logic                   in_fire;
	logic                   match_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			len_q      <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:  pat_low_q  <= cfg_wdata;
				REG_PATTERN_HIGH: pat_high_q <= cfg_wdata;
				REG_PATTERN_LEN:  len_q      <= cfg_wdata[LEN_FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	assign pat_word = {pat_high_q, pat_low_q};
	assign len_eff  = (len_q > LEN_FIELD_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
	                                                       : LEN_W'(len_q);

	assign text_in.ready = !buf_full;
	assign in_fire       = text_in.valid & text_in.ready;
	assign ctrl          = '{step: in_fire, start: text_in.start_of_text};

	// position zero: empty prefix, matches only the empty text
	assign link[0]    = '{base_bit: 1'b1, old_bit: text_in.start_of_text, new_bit: 1'b0};
	assign new_vec[0] = 1'b0;
	assign col_vec[0] = 1'b0;

	for (genvar i = 1; i <= PATTERN_MAX; i++) begin : g_cell
		wpm_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.pattern_char (pat_word[(i-1)*8 +: 8]),
			.text_char    (text_in.text_char),
			.enable       (LEN_W'(i) <= len_eff),
			.ctrl         (ctrl),
			.link_in      (link[i-1]),
			.link_out     (link[i]),
			.col_bit      (col_vec[i])
		);
		assign new_vec[i] = link[i].new_bit;
	end

	assign match_now = new_vec[len_eff];

	wpm_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_fire),
		.din    (match_now),
		.full   (buf_full),
		.out_ch (result)
	);

	a_empty_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && len_eff == '0) |-> !match_now)
		else $error("match reported for empty pattern");

	a_col_above_len: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> ((col_vec >> ($past(len_eff) + 1'b1)) == '0))
		else $error("column bit set above pattern length");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!text_in.ready |-> result.valid)
		else $error("input stalled with no result pending");

endmodule
